FILE: rtl/core/rvm_pkg.sv
// Package for the register VM execute unit: opcodes, crash causes, sizes
// and the command/status structs between controller and datapath.
// No dependencies.
package rvm_pkg;

  localparam int NumRegsDef    = 16;
  localparam int CallDepthDef  = 64;
  localparam int StackDepthDef = 64;
  localparam int DmemBytesDef  = 4096;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_MOVE = 6'd1, OP_LOAD_VAL = 6'd2, OP_READ_1 = 6'd3,
    OP_READ_2 = 6'd4, OP_READ_4 = 6'd5, OP_READ_8 = 6'd6, OP_READ = 6'd7,
    OP_WRITE_1 = 6'd8, OP_WRITE_2 = 6'd9, OP_WRITE_4 = 6'd10, OP_WRITE_8 = 6'd11,
    OP_WRITE = 6'd12, OP_ADD = 6'd13, OP_SUB = 6'd14, OP_MUL = 6'd15,
    OP_DIV = 6'd16, OP_REM = 6'd17, OP_CALL = 6'd18, OP_CALL_EXT = 6'd19,
    OP_RET = 6'd20, OP_JMPR = 6'd21, OP_JMP = 6'd22, OP_JEZ = 6'd23,
    OP_JEO = 6'd24, OP_JEZR = 6'd25, OP_JEOR = 6'd26, OP_CL = 6'd27,
    OP_CLE = 6'd28, OP_CG = 6'd29, OP_CGE = 6'd30, OP_CE = 6'd31,
    OP_CNE = 6'd32, OP_XOR = 6'd33, OP_OR = 6'd34, OP_NOT = 6'd35,
    OP_AND = 6'd36, OP_PUSH = 6'd37, OP_PUSHR = 6'd38, OP_POP = 6'd39,
    OP_CRASH = 6'd40
  } opcode_t;

  typedef enum logic [3:0] {
    CC_NONE = 4'd0, CC_BAD_ADDR = 4'd1, CC_RET_EMPTY = 4'd2, CC_POP_EMPTY = 4'd3,
    CC_BAD_OP = 4'd4, CC_CRASH_OP = 4'd5, CC_DIV_ZERO = 4'd6,
    CC_CALL_OVF = 4'd7, CC_PUSH_OVF = 4'd8, CC_BAD_LEN = 4'd9
  } cause_t;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_CRASH = 2'd1;
  localparam logic [1:0] ST_EXT = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_instr;   // capture the incoming word
    logic latch_ops;    // capture register file operands
    logic div_start;
    logic mul_start;
    logic mem_start;    // start byte-serial load/store
    logic stk_rd;       // issue stack read (RET/POP)
    logic commit;       // write back state and build the result
  } rvm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clearing;     // data memory clearing pass still running
    logic halted;
    logic is_div;
    logic is_mul;
    logic is_mem;
    logic is_stk_rd;
    logic div_done;
    logic mul_done;
    logic mem_done;
  } rvm_stat_t;

endpackage

FILE: rtl/core/rvm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rvm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/rvm_div.sv
// Radix-2 restoring divider for 64-bit signed div/rem, one bit per cycle.
// Depends on rvm_pkg.
module rvm_div import rvm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  logic [63:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt, qn_r, qn_nxt, rn_r, rn_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    busy_nxt = busy_r; done_nxt = 1'b0; cnt_nxt = cnt_r;
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; qn_nxt = qn_r; rn_nxt = rn_r;
    shifted = {r_r[62:0], q_r[63]};
    trial = {1'b0, shifted} - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1; cnt_nxt = 7'd0; r_nxt = '0;
      q_nxt = a[63] ? (64'd0 - a) : a;
      d_nxt = b[63] ? (64'd0 - b) : b;
      qn_nxt = a[63] ^ b[63]; rn_nxt = a[63];
    end else if (busy_r) begin
      if (!trial[64]) begin
        r_nxt = trial[63:0]; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = shifted; q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; qn_r <= qn_nxt; rn_r <= rn_nxt;
  end

  assign done = done_r;
  assign quot = qn_r ? (64'd0 - q_r) : q_r;
  assign rem  = rn_r ? (64'd0 - r_r) : r_r;
endmodule

FILE: rtl/core/rvm_datapath.sv
// Datapath of the VM execute unit: registers, pc, stacks, data memory,
// ALU, multiplier, divider and byte-serial memory sequencer.
// Depends on rvm_pkg, rvm_ram, rvm_div.
module rvm_datapath import rvm_pkg::*; #(
  parameter int NumRegs    = NumRegsDef,
  parameter int CallDepth  = CallDepthDef,
  parameter int StackDepth = StackDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rvm_cmd_t    cmd,
  input  logic [77:0] in_word,
  output rvm_stat_t   stat,
  output logic [31:0] res_next_pc,
  output logic [1:0]  res_status,
  output logic [3:0]  res_cause,
  output logic        res_wv,
  output logic [3:0]  res_widx,
  output logic [63:0] res_wval,
  output logic [31:0] res_ext
);
  localparam int DmemBytes = DmemBytesDef;
  localparam int RegW = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int CdW  = $clog2(CallDepth + 1);
  localparam int SdW  = $clog2(StackDepth + 1);
  localparam int CaW  = (CallDepth > 1) ? $clog2(CallDepth) : 1;
  localparam int SaW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int MaW  = $clog2(DmemBytes);

  logic [5:0]  op_r;
  logic [3:0]  d_r, s_r;
  logic [63:0] imm_r, a_r, b_r;
  logic [63:0] regs_r [NumRegs];
  logic [31:0] pc_r;
  logic [CdW-1:0] rdep_r;
  logic [SdW-1:0] vdep_r;
  logic        halt_r;
  logic [RegW-1:0] si;

  // The 4-bit index is reduced modulo the register count by repeated subtraction.
  function automatic logic [RegW-1:0] reg_index(logic [3:0] idx);
    int v;
    v = int'(idx);
    for (int i = 0; i < 16; i++) begin
      if (v >= NumRegs) v = v - NumRegs;
    end
    return RegW'(v);
  endfunction

  // Register index reduction for any register count.
  logic [RegW-1:0] d_mod, s_mod;
  assign d_mod = reg_index(d_r);
  assign s_mod = reg_index(s_r);
  assign si = s_mod;

  always_ff @(posedge clk) begin
    if (cmd.load_instr) begin
      op_r <= in_word[5:0]; d_r <= in_word[9:6];
      s_r <= in_word[13:10]; imm_r <= in_word[77:14];
    end
    if (cmd.latch_ops) begin
      a_r <= regs_r[d_mod]; b_r <= regs_r[si];
    end
  end

  // Decode of the latched instruction.
  logic is_rd, is_wr, len_ok;
  logic [3:0] nbytes;
  always_comb begin
    is_rd = (op_r >= OP_READ_1) && (op_r <= OP_READ);
    is_wr = (op_r >= OP_WRITE_1) && (op_r <= OP_WRITE);
    len_ok = (imm_r - 64'd1) < 64'd8;
    case (op_r)
      OP_READ_1, OP_WRITE_1: nbytes = 4'd1;
      OP_READ_2, OP_WRITE_2: nbytes = 4'd2;
      OP_READ_4, OP_WRITE_4: nbytes = 4'd4;
      OP_READ, OP_WRITE:     nbytes = imm_r[3:0];
      default:               nbytes = 4'd8;
    endcase
  end
  logic [63:0] maddr;
  assign maddr = is_rd ? b_r : a_r;
  assign stat.is_mem = (is_rd || is_wr) && maddr != 64'd0 &&
                       !((op_r == OP_READ || op_r == OP_WRITE) && !len_ok);
  assign stat.is_div = ((op_r == OP_DIV) || (op_r == OP_REM)) && b_r != 64'd0;
  assign stat.is_mul = op_r == OP_MUL;
  assign stat.is_stk_rd = (op_r == OP_RET) || (op_r == OP_POP);
  assign stat.halted = halt_r;

  // Multiplier: three 32x32 partial products, one per cycle, accumulated.
  logic [1:0]  mcnt_r;
  logic        mbusy_r, mdone_r;
  logic [63:0] macc_r, pp_r;
  logic [31:0] mx, my;
  logic        pvalid_r;
  logic [1:0]  pidx_r;
  always_comb begin
    mx = mcnt_r[0] ? a_r[63:32] : a_r[31:0];
    my = mcnt_r[1] ? b_r[63:32] : b_r[31:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0; mdone_r <= 1'b0; pvalid_r <= 1'b0;
    end else begin
      mdone_r <= 1'b0;
      pvalid_r <= mbusy_r;
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && mcnt_r == 2'd2) begin
        mbusy_r <= 1'b0;
      end
      if (pvalid_r && pidx_r == 2'd2) mdone_r <= 1'b1;
    end
    if (cmd.mul_start) begin
      mcnt_r <= 2'd0; macc_r <= '0;
    end else if (mbusy_r) begin
      mcnt_r <= mcnt_r + 2'd1;
    end
    pp_r <= mx * my;
    pidx_r <= mcnt_r;
    if (pvalid_r) begin
      if (pidx_r == 2'd0) macc_r <= macc_r + pp_r;
      else macc_r <= macc_r + {pp_r[31:0], 32'd0};
    end
  end
  assign stat.mul_done = mdone_r;

  // Divider.
  logic [63:0] quot, remd;
  rvm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .a(a_r), .b(b_r),
    .done(stat.div_done), .quot(quot), .rem(remd)
  );

  // Data memory with clearing pass and byte-serial access.
  logic [MaW:0]   clr_r;
  logic           clearing;
  logic           mbusy2_r, mdone2_r, rdv_r;
  logic [3:0]     bcnt_r, rcnt_r;
  logic [63:0]    ldv_r, sdat_r;
  logic [MaW-1:0] dm_addr;
  logic [7:0]     dm_wd, dm_rd;
  logic           dm_we;
  assign clearing = !clr_r[MaW];
  assign stat.clearing = clearing;
  always_comb begin
    if (clearing) begin
      dm_addr = clr_r[MaW-1:0]; dm_we = 1'b1; dm_wd = 8'd0;
    end else begin
      dm_addr = MaW'((maddr + 64'(bcnt_r)) % 64'(DmemBytes));
      dm_we = mbusy2_r && is_wr; dm_wd = sdat_r[7:0];
    end
  end
  rvm_ram #(.Width(8), .Depth(DmemBytes)) u_dmem (
    .clk(clk), .we(dm_we), .addr(dm_addr), .wdata(dm_wd), .rdata(dm_rd)
  );
  logic [63:0] ld_ext;
  always_comb begin
    ld_ext = ldv_r;
    case (nbytes)
      4'd1: ld_ext = {{56{ldv_r[7]}}, ldv_r[7:0]};
      4'd2: ld_ext = {{48{ldv_r[15]}}, ldv_r[15:0]};
      4'd3: ld_ext = {{40{ldv_r[23]}}, ldv_r[23:0]};
      4'd4: ld_ext = {{32{ldv_r[31]}}, ldv_r[31:0]};
      4'd5: ld_ext = {{24{ldv_r[39]}}, ldv_r[39:0]};
      4'd6: ld_ext = {{16{ldv_r[47]}}, ldv_r[47:0]};
      4'd7: ld_ext = {{8{ldv_r[55]}}, ldv_r[55:0]};
      default: ld_ext = ldv_r;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; mbusy2_r <= 1'b0; mdone2_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      if (clearing) clr_r <= clr_r + 1'b1;
      mdone2_r <= 1'b0;
      rdv_r <= mbusy2_r;
      if (cmd.mem_start) begin
        mbusy2_r <= 1'b1;
      end else if (mbusy2_r && bcnt_r == nbytes - 4'd1) begin
        mbusy2_r <= 1'b0;
        if (is_wr) mdone2_r <= 1'b1;
      end
      if (rdv_r && rcnt_r == nbytes - 4'd1) mdone2_r <= 1'b1;
    end
    if (cmd.mem_start) begin
      bcnt_r <= '0; sdat_r <= b_r; ldv_r <= '0;
    end else if (mbusy2_r) begin
      bcnt_r <= bcnt_r + 4'd1; sdat_r <= {8'd0, sdat_r[63:8]};
    end
    rcnt_r <= bcnt_r;
    if (rdv_r) ldv_r[rcnt_r[2:0]*8 +: 8] <= dm_rd;
  end
  assign stat.mem_done = mdone2_r && !clearing;

  // Stacks.
  logic [CaW-1:0] rs_addr;
  logic [SaW-1:0] vs_addr;
  logic [31:0] rs_rd, npc;
  logic [63:0] vs_rd;
  logic rs_we, vs_we;
  logic [3:0] cause;
  logic [31:0] npc_f;
  logic wv;
  logic [63:0] wval;
  logic [1:0] st;
  logic [31:0] ext;
  logic lt_ab, lt_ba;
  always_comb begin
    rs_addr = CaW'(rdep_r);
    vs_addr = SaW'(vdep_r);
    if (op_r == OP_RET) rs_addr = CaW'(rdep_r - 1'b1);
    if (op_r == OP_POP) vs_addr = SaW'(vdep_r - 1'b1);
  end

  always_comb begin
    lt_ab = $signed(a_r) < $signed(b_r);
    lt_ba = $signed(b_r) < $signed(a_r);
    npc = pc_r + 32'd1;
    cause = CC_NONE; wv = 1'b0; wval = '0; st = ST_RUN; ext = '0;
    rs_we = 1'b0; vs_we = 1'b0;
    case (op_r)
      OP_NOP: ;
      OP_MOVE: begin wv = 1'b1; wval = b_r; end
      OP_LOAD_VAL: begin wv = 1'b1; wval = imm_r; end
      OP_READ_1, OP_READ_2, OP_READ_4, OP_READ_8, OP_READ: begin
        if (op_r == OP_READ && !len_ok) cause = CC_BAD_LEN;
        else if (b_r == 64'd0) cause = CC_BAD_ADDR;
        else begin wv = 1'b1; wval = ld_ext; end
      end
      OP_WRITE_1, OP_WRITE_2, OP_WRITE_4, OP_WRITE_8, OP_WRITE: begin
        if (op_r == OP_WRITE && !len_ok) cause = CC_BAD_LEN;
        else if (a_r == 64'd0) cause = CC_BAD_ADDR;
      end
      OP_ADD: begin wv = 1'b1; wval = a_r + b_r; end
      OP_SUB: begin wv = 1'b1; wval = a_r - b_r; end
      OP_MUL: begin wv = 1'b1; wval = macc_r; end
      OP_DIV, OP_REM: begin
        if (b_r == 64'd0) cause = CC_DIV_ZERO;
        else begin wv = 1'b1; wval = (op_r == OP_DIV) ? quot : remd; end
      end
      OP_CALL: begin
        if (32'(rdep_r) >= CallDepth) cause = CC_CALL_OVF;
        else begin rs_we = 1'b1; npc = a_r[31:0]; end
      end
      OP_CALL_EXT: begin st = ST_EXT; ext = a_r[31:0]; end
      OP_RET: begin
        if (rdep_r == '0) cause = CC_RET_EMPTY;
        else npc = rs_rd;
      end
      OP_JMPR: npc = a_r[31:0];
      OP_JMP: npc = imm_r[31:0];
      OP_JEZ: if (a_r == 64'd0) npc = imm_r[31:0];
      OP_JEO: if (a_r == 64'd1) npc = imm_r[31:0];
      OP_JEZR: if (a_r == 64'd0) npc = b_r[31:0];
      OP_JEOR: if (a_r == 64'd1) npc = b_r[31:0];
      OP_CL: begin wv = 1'b1; wval = 64'(lt_ab); end
      OP_CLE: begin wv = 1'b1; wval = 64'(!lt_ba); end
      OP_CG: begin wv = 1'b1; wval = 64'(lt_ba); end
      OP_CGE: begin wv = 1'b1; wval = 64'(!lt_ab); end
      OP_CE: begin wv = 1'b1; wval = 64'(a_r == b_r); end
      OP_CNE: begin wv = 1'b1; wval = 64'(a_r != b_r); end
      OP_XOR: begin wv = 1'b1; wval = a_r ^ b_r; end
      OP_OR: begin wv = 1'b1; wval = a_r | b_r; end
      OP_NOT: begin wv = 1'b1; wval = ~a_r; end
      OP_AND: begin wv = 1'b1; wval = a_r & b_r; end
      OP_PUSH, OP_PUSHR: begin
        if (32'(vdep_r) >= StackDepth) cause = CC_PUSH_OVF;
        else vs_we = 1'b1;
      end
      OP_POP: begin
        if (vdep_r == '0) cause = CC_POP_EMPTY;
        else begin wv = 1'b1; wval = vs_rd; end
      end
      OP_CRASH: cause = CC_CRASH_OP;
      default: cause = CC_BAD_OP;
    endcase
    if (cause != CC_NONE) begin
      st = ST_CRASH; wv = 1'b0; wval = '0; npc = pc_r + 32'd1;
      rs_we = 1'b0; vs_we = 1'b0;
    end
    npc_f = npc;
  end

  rvm_ram #(.Width(32), .Depth(CallDepth)) u_rstk (
    .clk(clk), .we(rs_we && cmd.commit && !halt_r), .addr(rs_addr),
    .wdata(pc_r + 32'd1), .rdata(rs_rd)
  );
  rvm_ram #(.Width(64), .Depth(StackDepth)) u_vstk (
    .clk(clk), .we(vs_we && cmd.commit && !halt_r), .addr(vs_addr),
    .wdata((op_r == OP_PUSH) ? imm_r : a_r), .rdata(vs_rd)
  );

  // Commit and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; rdep_r <= '0; vdep_r <= '0; halt_r <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs_r[i] <= '0;
    end else if (cmd.commit) begin
      if (halt_r) begin
        res_next_pc <= pc_r; res_status <= ST_CRASH; res_cause <= CC_NONE;
        res_wv <= 1'b0; res_widx <= '0; res_wval <= '0; res_ext <= '0;
      end else begin
        pc_r <= npc_f;
        if (st == ST_CRASH) halt_r <= 1'b1;
        if (wv) regs_r[d_mod] <= wval;
        if (rs_we) rdep_r <= rdep_r + 1'b1;
        if (cause == CC_NONE && op_r == OP_RET) rdep_r <= rdep_r - 1'b1;
        if (vs_we) vdep_r <= vdep_r + 1'b1;
        if (cause == CC_NONE && op_r == OP_POP) vdep_r <= vdep_r - 1'b1;
        res_next_pc <= npc_f; res_status <= st; res_cause <= cause;
        res_wv <= wv; res_widx <= wv ? 4'(d_mod) : 4'd0;
        res_wval <= wval; res_ext <= ext;
      end
    end
  end
endmodule

FILE: rtl/core/rvm_ctrl.sv
// Controller state machine for the VM execute unit: input handshake,
// sequencing of multi-cycle units and the output register handshake.
// Depends on rvm_pkg.
module rvm_ctrl import rvm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  logic      mem_ready,
  input  rvm_stat_t stat,
  output rvm_cmd_t  cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_OPS = 7'b0000010, S_DISP = 7'b0000100,
    S_WAIT = 7'b0001000, S_STK = 7'b0010000, S_COMMIT = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (out_tvalid && out_tready) ov_nxt = 1'b0;
    in_tready = (state_r == S_IDLE) && mem_ready;
    unique case (state_r)
      S_IDLE: if (in_tvalid && mem_ready) begin
        cmd.load_instr = 1'b1; state_nxt = S_OPS;
      end
      S_OPS: begin cmd.latch_ops = 1'b1; state_nxt = S_DISP; end
      S_DISP: begin
        if (stat.halted) state_nxt = S_COMMIT;
        else if (stat.is_div) begin cmd.div_start = 1'b1; state_nxt = S_WAIT; end
        else if (stat.is_mul) begin cmd.mul_start = 1'b1; state_nxt = S_WAIT; end
        else if (stat.is_mem) begin cmd.mem_start = 1'b1; state_nxt = S_WAIT; end
        else if (stat.is_stk_rd) state_nxt = S_STK;
        else state_nxt = S_COMMIT;
      end
      S_WAIT: if (stat.div_done || stat.mul_done || stat.mem_done)
        state_nxt = S_COMMIT;
      S_STK: state_nxt = S_COMMIT;
      S_COMMIT: if (!ov_nxt) begin
        cmd.commit = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end
  assign out_tvalid = ov_r;
endmodule

FILE: rtl/core/register_vm_execute_unit_top.sv
// Register VM execute unit, top level. Each accepted word has its operands
// latched, is dispatched and is committed to the output register; RET/POP add
// a stack read, MUL three 32x32 partial products, DIV/REM a divider run (one
// quotient bit per cycle) and loads and stores a byte-serial memory access.
// A new word is taken the cycle after the commit; the commit waits while the
// previous result is not taken on out_tready. Reset: synchronous active-low;
// a clearing pass zeroes the data memory, during which in_tready stays low.
module register_vm_execute_unit_top import rvm_pkg::*; #(
  parameter int NUM_REGS    = NumRegsDef,
  parameter int CALL_DEPTH  = CallDepthDef,
  parameter int STACK_DEPTH = StackDepthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // cmd[5:0], dst_reg[9:6], src_reg[13:10], immediate[77:14]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // next_pc, status, crash_cause, write_valid,
                                   // write_index, write_value, ext_name_addr
);
  rvm_cmd_t  cmd;
  rvm_stat_t stat;
  logic [31:0] npc, ext;
  logic [1:0]  st;
  logic [3:0]  cause, widx;
  logic        wv;
  logic [63:0] wval;
  logic        unused_pad;

  assign unused_pad = ^in_tdata[79:78];

  rvm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .mem_ready(!stat.clearing), .stat(stat), .cmd(cmd)
  );

  rvm_datapath #(
    .NumRegs(NUM_REGS), .CallDepth(CALL_DEPTH),
    .StackDepth(STACK_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_tdata[77:0]), .stat(stat),
    .res_next_pc(npc), .res_status(st), .res_cause(cause), .res_wv(wv),
    .res_widx(widx), .res_wval(wval), .res_ext(ext)
  );

  assign out_tdata = {5'd0, ext, wval, widx, wv, cause, st, npc};
endmodule
